@@ rtl/plf_pkg.sv @@
// shared types and constants for the pid line follower steering block
// no dependencies; imported by every module of the block
`default_nettype none

package plf_pkg;

    // default sizes, handed to the top level parameters
    localparam int SAMPLE_BITS_DEF    = 10;
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int SUM_BITS_DEF       = 16;

    // fixed field widths
    localparam int GAIN_W  = 16;
    localparam int SPEED_W = 8;
    localparam int BLACK_W = 10;
    localparam int ERR_W   = 3;
    localparam int DERIV_W = 4;
    localparam int CAUSE_W = 2;
    localparam int FUNC_W  = 2;
    localparam int ADDR_W  = 3;

    // depth of the queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 4;

    // register reset values
    localparam logic [GAIN_W-1:0]  GAIN_PROP_RST  = 16'd3072;
    localparam logic [GAIN_W-1:0]  GAIN_INT_RST   = 16'd0;
    localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST = 16'd1280;
    localparam logic [SPEED_W-1:0] BASE_LEFT_RST  = 8'd35;
    localparam logic [SPEED_W-1:0] BASE_RIGHT_RST = 8'd32;
    localparam logic [BLACK_W-1:0] BLACK_RST      = 10'd700;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_GAIN_INT   = 3'd1;
    localparam logic [ADDR_W-1:0] REG_GAIN_DERIV = 3'd2;
    localparam logic [ADDR_W-1:0] REG_BASE_LEFT  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_BASE_RIGHT = 3'd4;
    localparam logic [ADDR_W-1:0] REG_BLACK      = 3'd5;

    // stop causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_NO_LINE = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_LOST    = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_ESTOP   = 2'd3;

    // command codes of an input word; the reserved code changes no state but still yields a word
    typedef enum logic [FUNC_W-1:0] {
        FN_TICK  = 2'd0,
        FN_START = 2'd1,
        FN_ESTOP = 2'd2,
        FN_RSVD  = 2'd3
    } t_func;

    // classified step handed from front to back
    typedef struct packed {
        logic               drive;    // compute speeds from the pid terms
        logic               running;
        logic [CAUSE_W-1:0] cause;
        logic [ERR_W-1:0]   err;      // signed position error
        logic [DERIV_W-1:0] deriv;    // signed error difference
    } t_work;

    localparam int WORK_W = $bits(t_work);

endpackage

`default_nettype wire

@@ rtl/plf_front.sv @@
// front part: thresholds the samples, maps the pattern to an error and keeps
// run state, error history and the saturating integral; uses plf_pkg
`default_nettype none

module plf_front #(
    parameter int SAMPLE_BITS = plf_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = plf_pkg::SUM_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [plf_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [SAMPLE_BITS-1:0]      i_left_sample,
    input  wire logic [SAMPLE_BITS-1:0]      i_mid_sample,
    input  wire logic [SAMPLE_BITS-1:0]      i_right_sample,
    input  wire logic [plf_pkg::BLACK_W-1:0] i_black_level,
    input  wire logic                        i_full,
    output logic                             o_push,
    output plf_pkg::t_work                   o_work,
    output logic [SUM_BITS-1:0]              o_sum
);
    import plf_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > BLACK_W) ? SAMPLE_BITS : BLACK_W;
    localparam logic signed [SUM_BITS:0] SUM_MAX = (SUM_BITS+1)'((64'd1 << (SUM_BITS-1)) - 1);
    localparam logic signed [SUM_BITS:0] SUM_MIN = -SUM_MAX;

    logic                      r_run;
    logic [ERR_W-1:0]          r_prev;
    logic [SUM_BITS-1:0]       r_sum;
    logic                      n_run;
    logic [ERR_W-1:0]          n_prev;
    logic [SUM_BITS-1:0]       n_sum;

    logic                      w_bl;
    logic                      w_bm;
    logic                      w_br;
    logic [2:0]                w_pat;
    logic                      w_lost;
    logic [ERR_W-1:0]          w_err;
    logic signed [SUM_BITS:0]  w_sum_ext;
    logic [DERIV_W-1:0]        w_deriv;
    t_work                     w_work;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // black decisions and pattern
    always_comb begin
        w_bl  = CMP_W'(i_left_sample)  > CMP_W'(i_black_level);
        w_bm  = CMP_W'(i_mid_sample)   > CMP_W'(i_black_level);
        w_br  = CMP_W'(i_right_sample) > CMP_W'(i_black_level);
        w_pat = {w_bl, w_bm, w_br};
    end

    // pattern to error; ambiguous patterns keep the previous error
    always_comb begin
        w_lost = 1'b0;
        case (w_pat)
            3'b100:  w_err = 3'b110;
            3'b110:  w_err = 3'b111;
            3'b010:  w_err = 3'b000;
            3'b011:  w_err = 3'b001;
            3'b001:  w_err = 3'b010;
            3'b000: begin
                w_err  = 3'b000;
                w_lost = 1'b1;
            end
            default: w_err = r_prev;
        endcase
    end

    // integral step with saturation, and difference
    always_comb begin
        w_sum_ext = $signed({r_sum[SUM_BITS-1], r_sum})
                  + (SUM_BITS+1)'($signed(w_err));
        if (w_sum_ext > SUM_MAX) begin
            w_sum_ext = SUM_MAX;
        end else if (w_sum_ext < SUM_MIN) begin
            w_sum_ext = SUM_MIN;
        end
        w_deriv = DERIV_W'($signed(w_err)) - DERIV_W'($signed(r_prev));
    end

    // command decode, next state and step record
    always_comb begin
        n_run  = r_run;
        n_prev = r_prev;
        n_sum  = r_sum;
        w_work = '0;
        case (t_func'(i_func))
            FN_START: begin
                n_prev         = '0;
                n_sum          = '0;
                n_run          = w_bm;
                w_work.running = w_bm;
                w_work.cause   = w_bm ? CAUSE_NONE : CAUSE_NO_LINE;
            end
            FN_ESTOP: begin
                n_run        = 1'b0;
                w_work.cause = CAUSE_ESTOP;
            end
            FN_RSVD: begin
                w_work.running = r_run;
                w_work.err     = r_prev;
            end
            FN_TICK: begin
                if (r_run && w_lost) begin
                    n_run        = 1'b0;
                    w_work.cause = CAUSE_LOST;
                end else if (r_run) begin
                    n_prev         = w_err;
                    n_sum          = w_sum_ext[SUM_BITS-1:0];
                    w_work.drive   = 1'b1;
                    w_work.running = 1'b1;
                    w_work.err     = w_err;
                    w_work.deriv   = w_deriv;
                end
            end
            default: begin
                w_work = '0;
            end
        endcase
    end

    assign o_work = w_work;
    assign o_sum  = n_sum;

    // state update on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_prev <= '0;
            r_sum  <= '0;
        end else if (o_push) begin
            r_run  <= n_run;
            r_prev <= n_prev;
            r_sum  <= n_sum;
        end
    end

endmodule

`default_nettype wire

@@ rtl/plf_queue.sv @@
// short register queue between front and back
// uses plf_pkg for the depth
`default_nettype none

module plf_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    import plf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic [PTR_W:0]   n_count;
    logic             w_pop;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/plf_back.sv @@
// back part: pid products, then wheel sums, truncation and clamp into the
// output register; uses plf_pkg
`default_nettype none

module plf_back #(
    parameter int GAIN_FRAC_BITS = plf_pkg::GAIN_FRAC_BITS_DEF,
    parameter int SUM_BITS       = plf_pkg::SUM_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_pop,
    input  wire plf_pkg::t_work              i_work,
    input  wire logic [SUM_BITS-1:0]         i_sum,
    input  wire logic [plf_pkg::GAIN_W-1:0]  i_gain_prop,
    input  wire logic [plf_pkg::GAIN_W-1:0]  i_gain_int,
    input  wire logic [plf_pkg::GAIN_W-1:0]  i_gain_deriv,
    input  wire logic [plf_pkg::SPEED_W-1:0] i_base_left,
    input  wire logic [plf_pkg::SPEED_W-1:0] i_base_right,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [plf_pkg::SPEED_W-1:0]      o_left_speed,
    output logic [plf_pkg::SPEED_W-1:0]      o_right_speed,
    output logic                             o_running,
    output logic [plf_pkg::CAUSE_W-1:0]      o_stop_cause,
    output logic [plf_pkg::ERR_W-1:0]        o_error_level
);
    import plf_pkg::*;

    localparam int PP_W = GAIN_W + ERR_W;
    localparam int PI_W = GAIN_W + SUM_BITS;
    localparam int PD_W = GAIN_W + DERIV_W;
    localparam int CW   = GAIN_W + SUM_BITS + 3;

    // product stage
    logic                     r_s1_valid;
    t_work                    r_s1_work;
    logic signed [PP_W-1:0]   r_p_prop;
    logic signed [PI_W-1:0]   r_p_int;
    logic signed [PD_W-1:0]   r_p_deriv;
    logic                     w_s1_ready;

    // output stage
    logic                     r_out_valid;
    logic [SPEED_W-1:0]       r_left;
    logic [SPEED_W-1:0]       r_right;
    logic                     r_running;
    logic [CAUSE_W-1:0]       r_cause;
    logic [ERR_W-1:0]         r_err;
    logic                     w_out_ready;

    logic signed [CW-1:0]     w_corr;
    logic signed [CW-1:0]     w_fl;
    logic signed [CW-1:0]     w_fr;
    logic signed [CW-1:0]     w_ql;
    logic signed [CW-1:0]     w_qr;
    logic [SPEED_W-1:0]       w_left;
    logic [SPEED_W-1:0]       w_right;

    assign w_out_ready = !r_out_valid || i_ready;
    assign w_s1_ready  = !r_s1_valid || w_out_ready;
    assign o_pop       = w_s1_ready;

    // multipliers, one per term
    always_ff @(posedge i_clk) begin
        if (i_valid && w_s1_ready) begin
            r_s1_work <= i_work;
            r_p_prop  <= $signed(i_gain_prop) * $signed(i_work.err);
            r_p_int   <= $signed(i_gain_int) * $signed(i_sum);
            r_p_deriv <= $signed(i_gain_deriv) * $signed(i_work.deriv);
        end
    end

    // correction, wheel sums and shift toward zero for positive sums
    always_comb begin
        w_corr = CW'(r_p_prop) + CW'(r_p_int) + CW'(r_p_deriv);
        w_fl   = (CW'($signed({1'b0, i_base_left})) <<< GAIN_FRAC_BITS) + w_corr;
        w_fr   = (CW'($signed({1'b0, i_base_right})) <<< GAIN_FRAC_BITS) - w_corr;
        w_ql   = w_fl >>> GAIN_FRAC_BITS;
        w_qr   = w_fr >>> GAIN_FRAC_BITS;
    end

    // clamp to the speed range
    always_comb begin
        if (!r_s1_work.drive || w_fl[CW-1] || (w_fl == '0)) begin
            w_left = '0;
        end else if (w_ql[CW-1:SPEED_W] != '0) begin
            w_left = '1;
        end else begin
            w_left = w_ql[SPEED_W-1:0];
        end
        if (!r_s1_work.drive || w_fr[CW-1] || (w_fr == '0)) begin
            w_right = '0;
        end else if (w_qr[CW-1:SPEED_W] != '0) begin
            w_right = '1;
        end else begin
            w_right = w_qr[SPEED_W-1:0];
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_out_ready) begin
            r_left    <= w_left;
            r_right   <= w_right;
            r_running <= r_s1_work.running;
            r_cause   <= r_s1_work.cause;
            r_err     <= r_s1_work.err;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_left_speed  = r_left;
    assign o_right_speed = r_right;
    assign o_running     = r_running;
    assign o_stop_cause  = r_cause;
    assign o_error_level = r_err;

endmodule

`default_nettype wire

@@ rtl/pid_line_follow_steer.sv @@
// pid line follower steering, top level: configuration registers, front,
// queue and back; uses plf_pkg, plf_front, plf_queue, plf_back
// path: an input word passes the queue, the product register and the output register
// throughput: one word per cycle while the queue is not full, set by the state update in front
// reset: synchronous active low; run stopped, history and integral cleared,
// registers back to their defaults, queue and pipeline emptied
`default_nettype none

module pid_line_follow_steer #(
    parameter int SAMPLE_BITS    = plf_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = plf_pkg::GAIN_FRAC_BITS_DEF,
    parameter int SUM_BITS       = plf_pkg::SUM_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata: left_sample, mid_sample, right_sample, zero fill
    input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // tuser: func
    input  wire logic [plf_pkg::FUNC_W-1:0]            s_axis_tuser,
    // output stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // tdata: left_speed, right_speed, running, stop_cause, error_level, zero fill
    output logic [23:0]                                m_axis_tdata,
    // configuration writes
    input  wire logic                                  i_cfg_we,
    input  wire logic [plf_pkg::ADDR_W-1:0]            i_cfg_addr,
    input  wire logic [plf_pkg::GAIN_W-1:0]            i_cfg_data
);
    import plf_pkg::*;

    localparam int QW = WORK_W + SUM_BITS;

    logic [GAIN_W-1:0]  r_gain_prop;
    logic [GAIN_W-1:0]  r_gain_int;
    logic [GAIN_W-1:0]  r_gain_deriv;
    logic [SPEED_W-1:0] r_base_left;
    logic [SPEED_W-1:0] r_base_right;
    logic [BLACK_W-1:0] r_black;

    logic               w_full;
    logic               w_push;
    t_work              w_front_work;
    logic [SUM_BITS-1:0] w_front_sum;
    logic               w_q_valid;
    logic [QW-1:0]      w_q_data;
    logic               w_pop;
    logic [SPEED_W-1:0] w_left_speed;
    logic [SPEED_W-1:0] w_right_speed;
    logic               w_running;
    logic [CAUSE_W-1:0] w_cause;
    logic [ERR_W-1:0]   w_err;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop  <= GAIN_PROP_RST;
            r_gain_int   <= GAIN_INT_RST;
            r_gain_deriv <= GAIN_DERIV_RST;
            r_base_left  <= BASE_LEFT_RST;
            r_base_right <= BASE_RIGHT_RST;
            r_black      <= BLACK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_GAIN_PROP:  r_gain_prop  <= i_cfg_data;
                REG_GAIN_INT:   r_gain_int   <= i_cfg_data;
                REG_GAIN_DERIV: r_gain_deriv <= i_cfg_data;
                REG_BASE_LEFT:  r_base_left  <= i_cfg_data[SPEED_W-1:0];
                REG_BASE_RIGHT: r_base_right <= i_cfg_data[SPEED_W-1:0];
                REG_BLACK:      r_black      <= i_cfg_data[BLACK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: classification and state
    plf_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_func         (s_axis_tuser),
        .i_left_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_mid_sample   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_right_sample (s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .i_black_level  (r_black),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_work         (w_front_work),
        .o_sum          (w_front_sum)
    );

    // queue between the two parts
    plf_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_sum, w_front_work}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // back: products, sums and clamp
    plf_back #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .SUM_BITS       (SUM_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .o_pop         (w_pop),
        .i_work        (t_work'(w_q_data[WORK_W-1:0])),
        .i_sum         (w_q_data[QW-1:WORK_W]),
        .i_gain_prop   (r_gain_prop),
        .i_gain_int    (r_gain_int),
        .i_gain_deriv  (r_gain_deriv),
        .i_base_left   (r_base_left),
        .i_base_right  (r_base_right),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_left_speed  (w_left_speed),
        .o_right_speed (w_right_speed),
        .o_running     (w_running),
        .o_stop_cause  (w_cause),
        .o_error_level (w_err)
    );

    // output word packing
    assign m_axis_tdata = {2'b00, w_err, w_cause, w_running, w_right_speed, w_left_speed};

endmodule

`default_nettype wire
